FILE: design/affa_pkg.sv
package affa_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_TYPE   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    localparam logic REG_CHUNK_BYTES    = 1'b0;
    localparam logic REG_CHUNK_MEM_TYPE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CHK,
        S_A_RD,
        S_A_PAD,
        S_A_FIT,
        S_A_ADV,
        S_A_END,
        S_F_PREP,
        S_F_RD,
        S_F_CMP,
        S_F_DEC,
        S_F_END,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_A_CHECK,
        CMD_A_ISSUE,
        CMD_A_PAD,
        CMD_A_FIT,
        CMD_A_ADV,
        CMD_A_END,
        CMD_F_PREP,
        CMD_F_ISSUE,
        CMD_F_CMP,
        CMD_F_DEC,
        CMD_F_END,
        CMD_PUBLISH
    } dp_cmd_t;

    typedef struct packed {
        logic type_ok;
        logic more;
        logic hit;
        logic fit;
        logic merge;
    } dp_stat_t;

endpackage

FILE: design/affa_req_if.sv
interface affa_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] req_bytes;
    logic [4:0]  align_log2;
    logic [4:0]  req_mem_type;
    logic [31:0] block_start;

    modport source (output valid, op, req_bytes, align_log2, req_mem_type, block_start,
                    input ready);
    modport sink (input valid, op, req_bytes, align_log2, req_mem_type, block_start,
                  output ready);
endinterface

FILE: design/affa_rsp_if.sv
interface affa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] bytes_in_use;
    logic [15:0] live_allocs;
    logic [6:0]  fragments_free;

    modport source (output valid, status, granted_offset, bytes_in_use, live_allocs,
                    fragments_free, input ready);
    modport sink (input valid, status, granted_offset, bytes_in_use, live_allocs,
                  fragments_free, output ready);
endinterface

FILE: design/affa_ctrl.sv
module affa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_ready,
    input  affa_pkg::dp_stat_t stat,
    output affa_pkg::dp_cmd_t  cmd,
    output logic               in_ready,
    output logic               out_valid
);

    affa_pkg::state_t state_reg;
    affa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == affa_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            affa_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = affa_pkg::S_A_CHK;
            end
            affa_pkg::S_A_CHK:  state_next = affa_pkg::S_A_CHK;
            affa_pkg::S_A_RD:   state_next = stat.more ? affa_pkg::S_A_PAD : affa_pkg::S_A_END;
            affa_pkg::S_A_PAD:  state_next = stat.hit ? affa_pkg::S_A_RD : affa_pkg::S_A_FIT;
            affa_pkg::S_A_FIT:  state_next = stat.fit ? affa_pkg::S_A_ADV : affa_pkg::S_A_RD;
            affa_pkg::S_A_ADV:  state_next = affa_pkg::S_A_RD;
            affa_pkg::S_A_END:  state_next = affa_pkg::S_DONE;
            affa_pkg::S_F_PREP: state_next = affa_pkg::S_F_RD;
            affa_pkg::S_F_RD:   state_next = stat.more ? affa_pkg::S_F_CMP : affa_pkg::S_F_END;
            affa_pkg::S_F_CMP:  state_next = affa_pkg::S_F_DEC;
            affa_pkg::S_F_DEC:  state_next = stat.merge ? affa_pkg::S_F_END : affa_pkg::S_F_RD;
            affa_pkg::S_F_END:  state_next = affa_pkg::S_DONE;
            affa_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = affa_pkg::S_IDLE;
            end
            default:            state_next = affa_pkg::S_IDLE;
        endcase
        // op is captured on entry; the check state routes free requests
        if (state_reg == affa_pkg::S_A_CHK)
        begin
            if (stat.hit)
                state_next = affa_pkg::S_F_PREP;
            else if (stat.type_ok)
                state_next = affa_pkg::S_A_RD;
            else
                state_next = affa_pkg::S_DONE;
        end
    end

    always_comb
    begin
        cmd = affa_pkg::CMD_NONE;
        case (state_reg)
            affa_pkg::S_IDLE:   cmd = in_valid ? affa_pkg::CMD_CAPTURE : affa_pkg::CMD_NONE;
            affa_pkg::S_A_CHK:  cmd = affa_pkg::CMD_A_CHECK;
            affa_pkg::S_A_RD:   cmd = affa_pkg::CMD_A_ISSUE;
            affa_pkg::S_A_PAD:  cmd = affa_pkg::CMD_A_PAD;
            affa_pkg::S_A_FIT:  cmd = affa_pkg::CMD_A_FIT;
            affa_pkg::S_A_ADV:  cmd = affa_pkg::CMD_A_ADV;
            affa_pkg::S_A_END:  cmd = affa_pkg::CMD_A_END;
            affa_pkg::S_F_PREP: cmd = affa_pkg::CMD_F_PREP;
            affa_pkg::S_F_RD:   cmd = affa_pkg::CMD_F_ISSUE;
            affa_pkg::S_F_CMP:  cmd = affa_pkg::CMD_F_CMP;
            affa_pkg::S_F_DEC:  cmd = affa_pkg::CMD_F_DEC;
            affa_pkg::S_F_END:  cmd = affa_pkg::CMD_F_END;
            affa_pkg::S_DONE:   cmd = out_free ? affa_pkg::CMD_PUBLISH : affa_pkg::CMD_NONE;
            default:            cmd = affa_pkg::CMD_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == affa_pkg::S_DONE && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= affa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == affa_pkg::S_IDLE)
        else $error("ready outside idle");
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == affa_pkg::S_DONE)
        else $error("result shown without finishing");
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == affa_pkg::S_IDLE && in_valid) |=> state_reg == affa_pkg::S_A_CHK)
        else $error("request lost");

endmodule

FILE: design/affa_dp.sv
module affa_dp #(
    parameter int MAXF = 16,
    parameter int OW   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  affa_pkg::dp_cmd_t  cmd,
    output affa_pkg::dp_stat_t stat,
    input  logic               in_op,
    input  logic [31:0]        in_req_bytes,
    input  logic [4:0]         in_align_log2,
    input  logic [4:0]         in_req_mem_type,
    input  logic [31:0]        in_block_start,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic [1:0]         out_status,
    output logic [31:0]        out_granted_offset,
    output logic [31:0]        out_bytes_in_use,
    output logic [15:0]        out_live_allocs,
    output logic [6:0]         out_fragments_free
);

    localparam int IW = (MAXF > 1) ? $clog2(MAXF) : 1;
    localparam int CW = $clog2(MAXF + 1);
    localparam int PW = (OW > 32) ? OW : 32;

    function automatic logic [OW-1:0] sat_add(input logic [OW-1:0] a, input logic [OW-1:0] b);
        logic [OW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OW] ? {OW{1'b1}} : s[OW-1:0];
    endfunction

    logic [OW-1:0] mem_start [MAXF];
    logic [OW-1:0] mem_len   [MAXF];

    // control state
    logic [31:0]   chunk_reg,  chunk_next;
    logic [4:0]    mtype_reg,  mtype_next;
    logic          fresh_reg,  fresh_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [31:0]   used_reg,   used_next;
    logic [15:0]   tally_reg,  tally_next;
    logic [CW-1:0] rptr_reg,   rptr_next;
    logic [CW-1:0] wptr_reg,   wptr_next;
    logic          hit_reg,    hit_next;
    logic          merged_reg, merged_next;

    // payload
    logic          op_reg,     op_next;
    logic [OW-1:0] req_reg,    req_next;
    logic [31:0]   req32_reg,  req32_next;
    logic [4:0]    lg_reg,     lg_next;
    logic [4:0]    imt_reg,    imt_next;
    logic [OW-1:0] bst_reg,    bst_next;
    logic [PW-1:0] pad_reg,    pad_next;
    logic [PW:0]   diff_reg,   diff_next;
    logic [OW-1:0] grant_reg,  grant_next;
    logic [OW-1:0] nlen_reg,   nlen_next;
    logic [OW-1:0] gapat_reg,  gapat_next;
    logic [OW-1:0] gap_reg,    gap_next;
    logic [OW-1:0] olen_reg,   olen_next;
    logic [IW-1:0] hidx_reg,   hidx_next;
    logic          m1_reg,     m1_next;
    logic [OW-1:0] endi_reg,   endi_next;
    logic [OW-1:0] lenp_reg,   lenp_next;
    logic [OW-1:0] rd_start_reg;
    logic [OW-1:0] rd_len_reg;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_grant_reg,  res_grant_next;
    logic [1:0]    o_status_reg;
    logic [31:0]   o_grant_reg;
    logic [31:0]   o_used_reg;
    logic [15:0]   o_tally_reg;
    logic [6:0]    o_frags_reg;

    logic          rd_en;
    logic          we;
    logic [IW-1:0] waddr;
    logic [OW-1:0] wst;
    logic [OW-1:0] wln;

    logic [PW-1:0] amask;
    logic [PW-1:0] rem;
    logic [PW-1:0] pad;
    logic [PW:0]   diff;
    logic          fit;
    logic          more;
    logic          merge;
    logic          gap_nz;
    logic [32:0]   used_sum;

    assign amask    = (PW'(1) << lg_reg) - PW'(1);
    assign rem      = PW'(rd_start_reg) & amask;
    assign pad      = (rem == '0) ? '0 : amask + PW'(1) - rem;
    assign diff     = (PW+1)'(rd_len_reg) - (PW+1)'(pad);
    assign fit      = !diff_reg[PW] && (diff_reg[PW-1:0] >= PW'(req_reg));
    assign more     = rptr_reg < count_reg;
    assign merge    = m1_reg || (endi_reg == bst_reg);
    assign gap_nz   = hit_reg && (gap_reg != '0);
    assign used_sum = {1'b0, used_reg} + {1'b0, req32_reg};

    assign stat.type_ok = (imt_reg == mtype_reg);
    assign stat.more    = more;
    assign stat.hit     = (cmd == affa_pkg::CMD_A_CHECK) ? op_reg : hit_reg;
    assign stat.fit     = fit;
    assign stat.merge   = merge;

    always_comb
    begin
        chunk_next      = chunk_reg;
        mtype_next      = mtype_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        tally_next      = tally_reg;
        rptr_next       = rptr_reg;
        wptr_next       = wptr_reg;
        hit_next        = hit_reg;
        merged_next     = merged_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        req32_next      = req32_reg;
        lg_next         = lg_reg;
        imt_next        = imt_reg;
        bst_next        = bst_reg;
        pad_next        = pad_reg;
        diff_next       = diff_reg;
        grant_next      = grant_reg;
        nlen_next       = nlen_reg;
        gapat_next      = gapat_reg;
        gap_next        = gap_reg;
        olen_next       = olen_reg;
        hidx_next       = hidx_reg;
        m1_next         = m1_reg;
        endi_next       = endi_reg;
        lenp_next       = lenp_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        rd_en           = 1'b0;
        we              = 1'b0;
        waddr           = wptr_reg[IW-1:0];
        wst             = rd_start_reg;
        wln             = rd_len_reg;

        case (cmd)
            affa_pkg::CMD_CAPTURE:
            begin
                op_next     = in_op;
                req_next    = OW'(in_req_bytes);
                req32_next  = 32'(OW'(in_req_bytes));
                lg_next     = in_align_log2;
                imt_next    = in_req_mem_type;
                bst_next    = OW'(in_block_start);
                rptr_next   = '0;
                wptr_next   = '0;
                hit_next    = 1'b0;
                merged_next = 1'b0;
            end
            affa_pkg::CMD_A_CHECK:
            begin
                res_status_next = affa_pkg::ST_TYPE;
                res_grant_next  = '0;
            end
            affa_pkg::CMD_A_ISSUE, affa_pkg::CMD_F_ISSUE:
            begin
                rd_en = more;
            end
            affa_pkg::CMD_A_PAD:
            begin
                if (hit_reg)
                begin
                    // compaction only, past the claimed fragment
                    we        = (rd_len_reg != '0);
                    wptr_next = wptr_reg + CW'(we);
                    rptr_next = rptr_reg + CW'(1);
                end
                else
                begin
                    pad_next  = pad;
                    diff_next = diff;
                end
            end
            affa_pkg::CMD_A_FIT:
            begin
                if (fit)
                begin
                    hit_next   = 1'b1;
                    grant_next = sat_add(rd_start_reg, OW'(pad_reg));
                    nlen_next  = OW'(diff_reg[PW-1:0]) - req_reg;
                    gapat_next = rd_start_reg;
                    gap_next   = OW'(pad_reg);
                    olen_next  = rd_len_reg;
                    hidx_next  = rptr_reg[IW-1:0];
                end
                else
                begin
                    we        = (rd_len_reg != '0);
                    wptr_next = wptr_reg + CW'(we);
                    rptr_next = rptr_reg + CW'(1);
                end
            end
            affa_pkg::CMD_A_ADV:
            begin
                wst       = sat_add(grant_reg, req_reg);
                wln       = nlen_reg;
                we        = (nlen_reg != '0);
                wptr_next = wptr_reg + CW'(we);
                rptr_next = rptr_reg + CW'(1);
            end
            affa_pkg::CMD_A_END:
            begin
                if (gap_nz && wptr_reg >= CW'(MAXF))
                begin
                    // table full: put the claimed fragment back as it was
                    we              = 1'b1;
                    waddr           = hidx_reg;
                    wst             = gapat_reg;
                    wln             = olen_reg;
                    res_status_next = affa_pkg::ST_FULL;
                    res_grant_next  = '0;
                end
                else
                begin
                    we         = gap_nz;
                    wst        = gapat_reg;
                    wln        = gap_reg;
                    count_next = wptr_reg + CW'(gap_nz);
                    if (hit_reg)
                    begin
                        res_status_next = affa_pkg::ST_OK;
                        res_grant_next  = 32'(grant_reg);
                        used_next       = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];
                        if (tally_reg != 16'hFFFF)
                            tally_next = tally_reg + 16'd1;
                    end
                    else
                    begin
                        res_status_next = affa_pkg::ST_NO_FIT;
                        res_grant_next  = '0;
                    end
                end
            end
            affa_pkg::CMD_F_PREP:
            begin
                grant_next = sat_add(bst_reg, req_reg);
            end
            affa_pkg::CMD_F_CMP:
            begin
                m1_next   = (grant_reg == rd_start_reg);
                endi_next = sat_add(rd_start_reg, rd_len_reg);
                lenp_next = sat_add(rd_len_reg, req_reg);
            end
            affa_pkg::CMD_F_DEC:
            begin
                waddr       = rptr_reg[IW-1:0];
                wst         = m1_reg ? bst_reg : rd_start_reg;
                wln         = lenp_reg;
                we          = merge;
                merged_next = merge;
                rptr_next   = rptr_reg + CW'(1);
            end
            affa_pkg::CMD_F_END:
            begin
                res_grant_next  = '0;
                res_status_next = affa_pkg::ST_OK;
                if (!merged_reg && count_reg >= CW'(MAXF))
                    res_status_next = affa_pkg::ST_FULL;
                else
                begin
                    if (!merged_reg)
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[IW-1:0];
                        wst        = bst_reg;
                        wln        = req_reg;
                        count_next = count_reg + CW'(1);
                    end
                    used_next = (used_reg > req32_reg) ? used_reg - req32_reg : '0;
                    if (tally_reg != '0)
                        tally_next = tally_reg - 16'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (we && waddr == '0)
            fresh_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                affa_pkg::REG_CHUNK_BYTES:
                begin
                    chunk_next = cfg_data;
                    fresh_next = 1'b1;
                    count_next = CW'(1);
                    used_next  = '0;
                    tally_next = '0;
                end
                affa_pkg::REG_CHUNK_MEM_TYPE:
                begin
                    mtype_next = cfg_data[4:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg      <= 32'hFFFF_FFFF;
            mtype_reg      <= '0;
            fresh_reg      <= 1'b1;
            count_reg      <= CW'(1);
            used_reg       <= '0;
            tally_reg      <= '0;
            rptr_reg       <= '0;
            wptr_reg       <= '0;
            hit_reg        <= 1'b0;
            merged_reg     <= 1'b0;
            res_status_reg <= affa_pkg::ST_OK;
        end
        else
        begin
            chunk_reg      <= chunk_next;
            mtype_reg      <= mtype_next;
            fresh_reg      <= fresh_next;
            count_reg      <= count_next;
            used_reg       <= used_next;
            tally_reg      <= tally_next;
            rptr_reg       <= rptr_next;
            wptr_reg       <= wptr_next;
            hit_reg        <= hit_next;
            merged_reg     <= merged_next;
            res_status_reg <= res_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        req_reg       <= req_next;
        req32_reg     <= req32_next;
        lg_reg        <= lg_next;
        imt_reg       <= imt_next;
        bst_reg       <= bst_next;
        pad_reg       <= pad_next;
        diff_reg      <= diff_next;
        grant_reg     <= grant_next;
        nlen_reg      <= nlen_next;
        gapat_reg     <= gapat_next;
        gap_reg       <= gap_next;
        olen_reg      <= olen_next;
        hidx_reg      <= hidx_next;
        m1_reg        <= m1_next;
        endi_reg      <= endi_next;
        lenp_reg      <= lenp_next;
        res_grant_reg <= res_grant_next;
        if (cmd == affa_pkg::CMD_PUBLISH)
        begin
            o_status_reg <= res_status_reg;
            o_grant_reg  <= res_grant_reg;
            o_used_reg   <= used_reg;
            o_tally_reg  <= tally_reg;
            o_frags_reg  <= 7'(count_reg);
        end
    end

    // fragment table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_start[waddr] <= wst;
            mem_len[waddr]   <= wln;
        end
        if (rd_en)
        begin
            if (fresh_reg && rptr_reg == '0)
            begin
                rd_start_reg <= '0;
                rd_len_reg   <= OW'(chunk_reg);
            end
            else
            begin
                rd_start_reg <= mem_start[rptr_reg[IW-1:0]];
                rd_len_reg   <= mem_len[rptr_reg[IW-1:0]];
            end
        end
    end

    assign out_status         = o_status_reg;
    assign out_granted_offset = o_grant_reg;
    assign out_bytes_in_use   = o_used_reg;
    assign out_live_allocs    = o_tally_reg;
    assign out_fragments_free = o_frags_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAXF))
        else $error("fragment count past table size");
    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg <= rptr_reg)
        else $error("compaction write ahead of read");
    a_full_grant: assert property (@(posedge clk) disable iff (!rst_n)
        res_status_reg == affa_pkg::ST_FULL |-> res_grant_reg == '0)
        else $error("grant on refused request");

endmodule

FILE: design/aligned_first_fit_fragment_allocator_core.sv
// channel | dir | handshake     | payload
// req     | in  | valid / ready | op, req_bytes, align_log2, req_mem_type, block_start
// rsp     | out | valid / ready | status, granted_offset, bytes_in_use, live_allocs,
//         |     |               | fragments_free
// cfg     | in  | cfg_we        | cfg_index, cfg_data
// one request at a time; the fragment table is a single-port memory walked one entry per step
// allocate: entries up to the fit are read, padded and fitted, the fitting one advanced, later
// ones read and compacted, then end; type mismatch goes to done; free: entries are read,
// compared and decided up to the merge, else a fragment is added; idle before the next request
// reset gives a table of one fragment covering the whole chunk, no clearing pass
// a finished result waits in the output register; the next request is taken meanwhile
module aligned_first_fit_fragment_allocator_core #(
    parameter int MAX_FRAGMENTS = 16,
    parameter int OFFSET_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    affa_req_if.sink    req,
    affa_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    affa_pkg::dp_cmd_t  cmd;
    affa_pkg::dp_stat_t stat;

    affa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (req.ready),
        .out_valid (rsp.valid)
    );

    affa_dp #(
        .MAXF (MAX_FRAGMENTS),
        .OW   (OFFSET_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .in_op              (req.op),
        .in_req_bytes       (req.req_bytes),
        .in_align_log2      (req.align_log2),
        .in_req_mem_type    (req.req_mem_type),
        .in_block_start     (req.block_start),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .out_status         (rsp.status),
        .out_granted_offset (rsp.granted_offset),
        .out_bytes_in_use   (rsp.bytes_in_use),
        .out_live_allocs    (rsp.live_allocs),
        .out_fragments_free (rsp.fragments_free)
    );

endmodule
